FILE: sv/knn_pkg.sv
`default_nettype none

package knn_pkg;

  // Build-time sizes of the selector.
  localparam int DIMS       = 4;
  localparam int K_MAX      = 16;
  localparam int COORD_BITS = 16;

  // Derived widths.
  localparam int CNT_W      = $clog2(K_MAX + 1);
  localparam int IDX_W      = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int DIST_W     = 2 * COORD_BITS + 3;
  localparam int OUT_DIST_W = 2 * COORD_BITS + 2;
  localparam int ID_W       = 16;
  localparam int DIMS_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_K       = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [DIMS_W-1:0] DIMS_RESET = 3'd4;
  localparam logic [CNT_W-1:0]  K_RESET    = CNT_W'(1);

  // Request codes.
  localparam logic REQ_POINT = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef logic [DIMS-1:0][COORD_BITS-1:0] coord_vec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_INSERT,
    ST_FLUSH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_point;
    logic square;
    logic sum;
    logic insert;
    logic flush_start;
    logic flush_pop;
    logic flush_done;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rem_zero;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

FILE: sv/knn_ctrl.sv
`default_nettype none

module knn_ctrl (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  input  wire             in_req_type,
  output logic            in_stall,
  output knn_pkg::cmd_t   cmd,
  input  knn_pkg::status_t status
);
  import knn_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_req_type == REQ_FLUSH) begin
            cmd.flush_start = 1'b1;
            state_nxt       = ST_FLUSH;
          end else begin
            cmd.load_point = 1'b1;
            state_nxt      = ST_SQUARE;
          end
        end
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_INSERT;
      end
      ST_INSERT: begin
        cmd.insert = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_FLUSH: begin
        if (status.rem_zero) begin
          cmd.flush_done = 1'b1;
          state_nxt      = ST_IDLE;
        end else if (status.out_free) begin
          cmd.flush_pop = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/knn_dpath.sv
`default_nettype none

module knn_dpath (
  input  wire                                      clk,
  input  wire                                      rst_n,
  input  wire                                      cfg_we,
  input  wire [knn_pkg::CFG_IDX_W-1:0]             cfg_index,
  input  wire [knn_pkg::CFG_DATA_W-1:0]            cfg_data,
  input  knn_pkg::coord_vec_t                      in_coords,
  input  wire [knn_pkg::ID_W-1:0]                  in_object_id,
  input  knn_pkg::cmd_t                            cmd,
  output knn_pkg::status_t                         status,
  input  wire                                      out_stall,
  output logic                                     out_valid,
  output logic [knn_pkg::ID_W-1:0]                 out_result_id,
  output logic [knn_pkg::OUT_DIST_W-1:0]           out_distance_sq,
  output logic                                     out_last_of_run
);
  import knn_pkg::*;

  // Configuration registers.
  logic [DIMS-1:0][COORD_BITS-1:0] query_r;
  logic [DIMS_W-1:0]               dims_r;
  logic [CNT_W-1:0]                k_r;

  // Distance pipeline.
  logic [DIMS-1:0][COORD_BITS-1:0]   absdiff_r;
  logic [DIMS-1:0][COORD_BITS-1:0]   absdiff_nxt;
  logic [DIMS-1:0][2*COORD_BITS-1:0] square_r;
  logic [DIST_W-1:0]                 dist_r;
  logic [DIST_W-1:0]                 dist_nxt;
  logic [ID_W-1:0]                   id_r;

  // Kept entries, ascending by distance.
  logic [DIST_W-1:0] best_dist_r [K_MAX];
  logic [ID_W-1:0]   best_obj_r  [K_MAX];
  logic [CNT_W-1:0]  fill_r;
  logic [CNT_W-1:0]  rem_r;

  // Output register.
  logic                  out_valid_r;
  logic [ID_W-1:0]       out_id_r;
  logic [OUT_DIST_W-1:0] out_dist_r;
  logic                  out_last_r;

  logic [CNT_W-1:0]  k_eff;
  logic [DIMS_W-1:0] dims_eff;
  logic [CNT_W-1:0]  fill_eff;
  logic [CNT_W-1:0]  k_minus_1;
  logic [K_MAX-1:0]  le_vec;
  logic              take_new;

  // Saturated configuration values and the fill clamped to k.
  always_comb begin
    k_eff     = (k_r > CNT_W'(K_MAX)) ? CNT_W'(K_MAX) : k_r;
    dims_eff  = (dims_r > DIMS_W'(DIMS)) ? DIMS_W'(DIMS) : dims_r;
    fill_eff  = (fill_r > k_eff) ? k_eff : fill_r;
    k_minus_1 = k_eff - CNT_W'(1);
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_r <= '0;
      dims_r  <= DIMS_RESET;
      k_r     <= K_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_DIMS) begin
        dims_r <= cfg_data[DIMS_W-1:0];
      end else if (cfg_index == CFG_K) begin
        k_r <= cfg_data[CNT_W-1:0];
      end else begin
        for (int d = 0; d < DIMS; d++) begin
          if (cfg_index == CFG_QUERY_0 + CFG_IDX_W'(d)) begin
            query_r[d] <= cfg_data[COORD_BITS-1:0];
          end
        end
      end
    end
  end

  // Absolute coordinate differences; unused dimensions contribute zero.
  always_comb begin
    logic [COORD_BITS:0] diff;
    logic [COORD_BITS:0] mag;
    for (int d = 0; d < DIMS; d++) begin
      diff = {in_coords[d][COORD_BITS-1], in_coords[d]}
             - {query_r[d][COORD_BITS-1], query_r[d]};
      mag  = diff[COORD_BITS] ? (~diff + (COORD_BITS+1)'(1)) : diff;
      absdiff_nxt[d] = (DIMS_W'(d) < dims_eff) ? mag[COORD_BITS-1:0] : '0;
    end
  end

  // Sum of the squares.
  always_comb begin
    dist_nxt = '0;
    for (int d = 0; d < DIMS; d++) begin
      dist_nxt = dist_nxt + DIST_W'(square_r[d]);
    end
  end

  // Distance pipeline registers: differences, squares, sum.
  always_ff @(posedge clk) begin
    if (cmd.load_point) begin
      absdiff_r <= absdiff_nxt;
      id_r      <= in_object_id;
    end
    if (cmd.square) begin
      for (int d = 0; d < DIMS; d++) begin
        square_r[d] <= (2*COORD_BITS)'(absdiff_r[d]) * (2*COORD_BITS)'(absdiff_r[d]);
      end
    end
    if (cmd.sum) begin
      dist_r <= dist_nxt;
    end
  end

  // Entries at or below the new distance; a sorted table makes this a prefix.
  always_comb begin
    for (int i = 0; i < K_MAX; i++) begin
      le_vec[i] = (CNT_W'(i) < fill_eff) && (best_dist_r[i] <= dist_r);
    end
    take_new = (k_eff != '0)
               && ((fill_eff < k_eff) || !le_vec[k_minus_1[IDX_W-1:0]]);
  end

  // Table: sorted insertion, or shift toward the head while flushing.
  always_ff @(posedge clk) begin
    if (cmd.insert && take_new) begin
      for (int i = 0; i < K_MAX; i++) begin
        if (!le_vec[i]) begin
          if (i == 0) begin
            best_dist_r[i] <= dist_r;
            best_obj_r[i]  <= id_r;
          end else if (le_vec[(i == 0) ? 0 : i-1]) begin
            best_dist_r[i] <= dist_r;
            best_obj_r[i]  <= id_r;
          end else begin
            best_dist_r[i] <= best_dist_r[(i == 0) ? 0 : i-1];
            best_obj_r[i]  <= best_obj_r[(i == 0) ? 0 : i-1];
          end
        end
      end
    end else if (cmd.flush_pop) begin
      for (int i = 0; i < K_MAX - 1; i++) begin
        best_dist_r[i] <= best_dist_r[i+1];
        best_obj_r[i]  <= best_obj_r[i+1];
      end
    end
  end

  // Fill count and flush countdown. Any offer with k above zero truncates the
  // table to k, even when the newcomer is rejected.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      rem_r  <= '0;
    end else begin
      if (cmd.insert && take_new) begin
        fill_r <= (fill_eff == k_eff) ? k_eff : fill_eff + CNT_W'(1);
      end else if (cmd.insert && (k_eff != '0)) begin
        fill_r <= fill_eff;
      end else if (cmd.flush_done) begin
        fill_r <= '0;
      end
      if (cmd.flush_start) begin
        rem_r <= fill_eff;
      end else if (cmd.flush_pop) begin
        rem_r <= rem_r - CNT_W'(1);
      end
    end
  end

  // Output register: holds a result until its transfer completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.flush_pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.flush_pop) begin
      out_id_r   <= best_obj_r[0];
      out_dist_r <= best_dist_r[0][OUT_DIST_W-1:0];
      out_last_r <= (rem_r == CNT_W'(1));
    end
  end

  assign status.rem_zero = (rem_r == '0);
  assign status.out_free = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_result_id   = out_id_r;
  assign out_distance_sq = out_dist_r;
  assign out_last_of_run = out_last_r;

endmodule

`default_nettype wire

FILE: sv/knn_top_k_selector.sv
`default_nettype none

// Brute-force k-nearest-neighbor selector. Write the query point, the number
// of dimensions in use and k through the cfg_ port while the block is idle.
// Each data point (req_type 0) is scored by squared Euclidean distance over
// the leading dimensions and kept if it is among the k nearest so far; ties
// keep arrival order. A flush request (req_type 1) returns the kept entries
// nearest first, marks the final one with out_last_of_run, and empties the
// table; with k of zero or an empty table a flush returns nothing. A data
// point passes through the difference stage, one multiplier per dimension, an
// adder tree, then a parallel compare and insert into the 16-entry sorted
// table, and the input stalls until it is done. A flush returns one entry per
// cycle from the table head when the output is not stalled.

module knn_top_k_selector (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  cfg_we,
  input  wire [knn_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire [knn_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire                                  in_req_type,
  input  wire signed [knn_pkg::COORD_BITS-1:0] in_point_coord_0,
  input  wire signed [knn_pkg::COORD_BITS-1:0] in_point_coord_1,
  input  wire signed [knn_pkg::COORD_BITS-1:0] in_point_coord_2,
  input  wire signed [knn_pkg::COORD_BITS-1:0] in_point_coord_3,
  input  wire [knn_pkg::ID_W-1:0]              in_object_id,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [knn_pkg::ID_W-1:0]             out_result_id,
  output logic [knn_pkg::OUT_DIST_W-1:0]       out_distance_sq,
  output logic                                 out_last_of_run
);
  import knn_pkg::*;

  cmd_t       cmd;
  status_t    status;
  coord_vec_t in_coords;

  assign in_coords = {in_point_coord_3, in_point_coord_2,
                      in_point_coord_1, in_point_coord_0};

  knn_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .status      (status)
  );

  knn_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_coords       (in_coords),
    .in_object_id    (in_object_id),
    .cmd             (cmd),
    .status          (status),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_result_id   (out_result_id),
    .out_distance_sq (out_distance_sq),
    .out_last_of_run (out_last_of_run)
  );

endmodule

`default_nettype wire
